@@ hw/rtl/sgd_pkg.sv @@
package sgd_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int SGS_W   = 6;
  localparam int MAXB_W  = 23;
  localparam int LEN_W   = 24;
  localparam int ADDR_W  = 64;
  localparam int FLAG_W  = 5;
  localparam int DWC_W   = 22;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [SGS_W-1:0]  SLOT_LIMIT    = 6'd32;
  localparam logic [SGS_W-1:0]  SGS_RESET     = 6'd4;
  localparam logic [MAXB_W-1:0] MAXB_RESET    = 23'd4194300;

  localparam logic [FLAG_W-1:0] FLAG_NONE      = 5'h00;
  localparam logic [FLAG_W-1:0] FLAG_JOB_START = 5'h09;
  localparam logic [FLAG_W-1:0] FLAG_JOB_END   = 5'h06;
  localparam logic [FLAG_W-1:0] FLAG_XFER_END  = 5'h04;
  localparam logic [FLAG_W-1:0] FLAG_ERROR     = 5'h16;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_ARM    = 2'd2;
  localparam logic [1:0] OP_XFER   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SGS_PER_TRANSFER  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEMENT_BYTES = 4'd1;

  typedef struct packed {
    logic [1:0]        op;
    logic [LEN_W-1:0]  entry_length;
    logic [ADDR_W-1:0] entry_address;
  } item_t;

  typedef struct packed {
    logic [FLAG_W-1:0] desc_flags;
    logic [DWC_W-1:0]  dword_count;
    logic [ADDR_W-1:0] desc_address;
    logic              job_finished;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [SGS_W-1:0]  sgs_per_transfer;
    logic [MAXB_W-1:0] max_element_bytes;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] address;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    entry_t           wdata;
  } mem_req_t;

endpackage

@@ hw/rtl/sgd_store.sv @@
module sgd_store import sgd_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

@@ hw/rtl/sgd_walker.sv @@
module sgd_walker import sgd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  item_t    item,
  input  cfg_t     cfg,
  input  entry_t   rdata,
  output mem_req_t req,
  output logic     busy,
  output logic     result_valid,
  output result_t  result
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] next_index;
  logic [CNT_W-1:0] items_left;
  logic [SGS_W-1:0] slot_cnt;
  logic [SGS_W-1:0] slots;
  logic             first_desc;

  logic             accept;
  logic [SGS_W-1:0] slots_eff;
  logic             bad_len;
  logic             job_end;
  logic             slot_end;
  logic             walk_done;
  logic [FLAG_W-1:0] flags;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state == ST_EMIT);
  assign slots_eff = (cfg.sgs_per_transfer > SLOT_LIMIT) ? SLOT_LIMIT : cfg.sgs_per_transfer;

  always_comb begin
    bad_len   = (rdata.length[1:0] != 2'b00) ||
                (rdata.length > {1'b0, cfg.max_element_bytes});
    job_end   = (items_left == CNT_W'(1));
    slot_end  = (slot_cnt == slots - SGS_W'(1));
    walk_done = bad_len || job_end || slot_end;
    flags     = (first_desc ? FLAG_JOB_START : FLAG_NONE) |
                (job_end ? FLAG_JOB_END : FLAG_NONE) |
                (slot_end ? FLAG_XFER_END : FLAG_NONE) |
                (bad_len ? FLAG_ERROR : FLAG_NONE);
  end

  // The entry after the current one is fetched while the current one is
  // emitted, so a walk yields one descriptor per cycle. Appends only happen
  // while idle, so a walk never reads an entry written in the same cycle.
  always_comb begin
    req.we    = accept && (item.op == OP_APPEND) && (entry_count < CNT_W'(MAX_ENTRIES));
    req.waddr = entry_count[IDX_W-1:0];
    req.wdata = '{length: item.entry_length, address: item.entry_address};
    if (state == ST_EMIT) begin
      req.raddr = next_index[IDX_W-1:0] + IDX_W'(1);
    end else begin
      req.raddr = next_index[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_count  <= '0;
      next_index   <= '0;
      items_left   <= '0;
      slot_cnt     <= '0;
      slots        <= '0;
      first_desc   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (item.op)
              OP_CLEAR: begin
                entry_count <= '0;
                next_index  <= '0;
                items_left  <= '0;
              end
              OP_APPEND: begin
                if (req.we) begin
                  entry_count <= entry_count + CNT_W'(1);
                end
              end
              OP_ARM: begin
                items_left <= entry_count;
                next_index <= '0;
              end
              OP_XFER: begin
                if (items_left != '0 && slots_eff != '0) begin
                  state      <= ST_EMIT;
                  slot_cnt   <= '0;
                  slots      <= slots_eff;
                  first_desc <= (next_index == '0);
                end
              end
              default: ;
            endcase
          end
        end
        ST_EMIT: begin
          result_valid <= 1'b1;
          next_index   <= next_index + CNT_W'(1);
          items_left   <= items_left - CNT_W'(1);
          slot_cnt     <= slot_cnt + SGS_W'(1);
          first_desc   <= 1'b0;
          if (walk_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      result.desc_flags   <= flags;
      result.dword_count  <= rdata.length[LEN_W-1:2];
      result.desc_address <= rdata.address;
      result.job_finished <= job_end;
      result.last         <= walk_done;
    end
  end

endmodule

@@ hw/rtl/sg_dma_descriptor_generator.sv @@
// Channel   Handshake                  Payload
// command   start / busy               item   (op, entry_length, entry_address)
// result    result_valid (strobe)      result (desc_flags, dword_count,
//                                              desc_address, job_finished, last)
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Clear, append and arm leave busy low. A transfer request holds busy
// while it produces its descriptors (up to 32); the first descriptor
// strobes once the request has moved the walker into its emit state and
// the result register has loaded, then one per cycle, paced by the list
// memory's single read port. Synchronous reset clears the counters and
// returns the configuration to its defaults; the list memory is not
// cleared. The receiver cannot stall results.
module sg_dma_descriptor_generator import sgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item,
  output logic                  result_valid,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg;
  mem_req_t req;
  entry_t   rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sgs_per_transfer  <= SGS_RESET;
      cfg.max_element_bytes <= MAXB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SGS_PER_TRANSFER:  cfg.sgs_per_transfer  <= cfg_data[SGS_W-1:0];
        CFG_MAX_ELEMENT_BYTES: cfg.max_element_bytes <= cfg_data[MAXB_W-1:0];
        default: ;
      endcase
    end
  end

  sgd_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  sgd_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .cfg          (cfg),
    .rdata        (rdata),
    .req          (req),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

@@ hw/rtl/sgd_checker.sv @@
module sgd_checker import sgd_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    result_valid,
  input result_t result
);

  // Every descriptor comes out of a walk that was in progress in the previous cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a walk in progress");

  // Descriptors of one transfer follow each other without gaps.
  a_walk_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid)
    else $error("gap inside a transfer");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |=> !result_valid)
    else $error("descriptor directly after the last one of a transfer");

  a_job_end_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.job_finished |-> result.last)
    else $error("job finished but transfer continued");

  // List commands other than a transfer request never occupy the block.
  a_list_ops_quick: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.op != OP_XFER |=> !busy)
    else $error("list command left the block busy");

endmodule

bind sg_dma_descriptor_generator sgd_checker u_sgd_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .item         (item),
  .result_valid (result_valid),
  .result       (result)
);
